/* design/spq_pkg.sv */
// Shared types and codes for the sorted priority queue.
package spq_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int KEY_W = 16;
  localparam int RANK_W = 16;
  localparam int OCC_W = 5;

  typedef struct packed {
    logic [1:0]               cmd;
    logic [KEY_W-1:0]         entry_key;
    logic signed [RANK_W-1:0] entry_rank;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [KEY_W-1:0]         popped_key;
    logic [KEY_W-1:0]         front_key;
    logic signed [RANK_W-1:0] front_rank;
    logic [OCC_W-1:0]         occupancy;
    logic                     is_empty;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic apply;
  } ctl_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

endpackage

/* design/spq_datapath.sv */
// Datapath: item register, row of compare-and-shift cells, fill count and result register.
module spq_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  spq_pkg::ctl_t   ctl,
  input  spq_pkg::in_t    in_data,
  output spq_pkg::out_t   out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  spq_pkg::in_t                       item_r;
  logic [spq_pkg::KEY_W-1:0]          key_r    [CAPACITY];
  logic signed [spq_pkg::RANK_W-1:0]  rank_r   [CAPACITY];
  logic [spq_pkg::KEY_W-1:0]          key_nxt  [CAPACITY];
  logic signed [spq_pkg::RANK_W-1:0]  rank_nxt [CAPACITY];
  logic [CNT_W-1:0]                   count_r;
  logic [CNT_W-1:0]                   count_nxt;
  logic [CAPACITY-1:0]                gt;
  logic [CAPACITY-1:0]                gt_prev;
  logic                               full;
  logic                               empty;
  spq_pkg::out_t                      res;
  spq_pkg::out_t                      out_r;

  assign full    = (count_r == CNT_W'(CAPACITY));
  assign empty   = (count_r == '0);
  assign gt_prev = {gt[CAPACITY-2:0], 1'b0};

  // Each occupied cell compares its own rank against the new one.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i] = (CNT_W'(i) < count_r) && (rank_r[i] > item_r.entry_rank);
    end
  end

  always_comb begin
    key_nxt        = key_r;
    rank_nxt       = rank_r;
    count_nxt      = count_r;
    res.status     = spq_pkg::ST_OK;
    res.popped_key = '0;
    case (item_r.cmd)
      spq_pkg::CMD_INSERT: begin
        if (full) begin
          res.status = spq_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (gt[i] || (CNT_W'(i) == count_r)) begin
              if (gt_prev[i]) begin
                key_nxt[i]  = key_r[i-1];
                rank_nxt[i] = rank_r[i-1];
              end else begin
                key_nxt[i]  = item_r.entry_key;
                rank_nxt[i] = item_r.entry_rank;
              end
            end
          end
          count_nxt = count_r + 1'b1;
        end
      end
      spq_pkg::CMD_POP: begin
        if (empty) begin
          res.status = spq_pkg::ST_EMPTY;
        end else begin
          res.popped_key = key_r[0];
          for (int i = 0; i < CAPACITY - 1; i++) begin
            key_nxt[i]  = key_r[i+1];
            rank_nxt[i] = rank_r[i+1];
          end
          count_nxt = count_r - 1'b1;
        end
      end
      spq_pkg::CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
    res.is_empty   = (count_nxt == '0);
    res.front_key  = res.is_empty ? '0 : key_nxt[0];
    res.front_rank = res.is_empty ? '0 : rank_nxt[0];
    res.occupancy  = spq_pkg::OCC_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.apply) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item_r <= in_data;
    end
    if (ctl.apply) begin
      key_r  <= key_nxt;
      rank_r <= rank_nxt;
      out_r  <= res;
    end
  end

  assign out_data = out_r;

endmodule

/* design/spq_ctrl.sv */
// Controller: state machine that sequences capture, apply and the output beat.
module spq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output spq_pkg::ctl_t ctl
);

  spq_pkg::state_t state_r;
  spq_pkg::state_t state_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;

  assign in_stall    = (state_r != spq_pkg::S_IDLE);
  assign ctl.capture = in_valid && !in_stall;
  assign ctl.apply   = (state_r == spq_pkg::S_EXEC) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spq_pkg::S_IDLE: begin
        if (ctl.capture) begin
          state_nxt = spq_pkg::S_EXEC;
        end
      end
      spq_pkg::S_EXEC: begin
        if (ctl.apply) begin
          state_nxt = spq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
    out_valid_nxt = ctl.apply || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_capture_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.capture |=> (state_r == spq_pkg::S_EXEC))
    else $error("captured beat did not move the controller to execute");

  a_apply_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.apply |-> (state_r == spq_pkg::S_EXEC))
    else $error("datapath update outside execute state");

  a_valid_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.apply))
    else $error("result valid without a datapath update");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !ctl.apply)
    else $error("pending result overwritten");

endmodule

/* design/sorted_priority_queue_top.sv */
// Top level of the sorted priority queue: controller and datapath.
// A command beat taken by the capture step is held in the item register; the apply step then
// loads its result into the output register once no earlier result is left waiting there.
// The output register lets the next command beat be taken while a result still waits.
// Reset (rst_n, synchronous, active low) empties the queue and drops any pending result;
// slot contents are not cleared, since only slots below the fill count are ever read.
module sorted_priority_queue_top #(
  parameter int CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  spq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output spq_pkg::out_t out_data
);

  // The controller hands the datapath two commands: capture latches the incoming
  // beat, apply performs the insert, pop or clear on every cell at once and loads
  // the result register.
  spq_pkg::ctl_t ctl;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // The datapath keeps the entries as a sorted row of cells. On insert, every
  // cell whose rank is strictly greater than the new one shifts back by one, so
  // equal ranks stay in arrival order; on pop, every cell shifts forward.
  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

/* sim/sorted_priority_queue_top_tb.sv */
// Self-checking testbench for the sorted priority queue: directed and random command beats.
`timescale 1ns / 100ps

module sorted_priority_queue_top_tb;

  localparam int CAPACITY = 16;
  // Command code 3 is not defined by the block; it must be ignored.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int BEATS_PER_PHASE = 230;

  // The scoreboard keeps its own sorted copy of the queue contents. Every
  // accepted command beat is applied to that copy at once, and the result
  // the block should report is queued until its result beat arrives.
  class urgency_scoreboard;
    int capacity;
    logic [spq_pkg::KEY_W-1:0] held_key[$];
    logic signed [spq_pkg::RANK_W-1:0] held_rank[$];
    spq_pkg::out_t awaited_results[$];
    int errors;
    int n_insert, n_dropped, n_pop, n_pop_empty, n_clear, n_ignored, peak_fill;

    function new(int cap);
      capacity = cap;
    endfunction

    function void note_command(spq_pkg::in_t beat);
      spq_pkg::out_t res;
      int pos;
      res = '0;
      res.status = spq_pkg::ST_OK;
      case (beat.cmd)
        spq_pkg::CMD_INSERT: begin
          n_insert++;
          if (held_key.size() >= capacity) begin
            res.status = spq_pkg::ST_FULL;
            n_dropped++;
          end else begin
            // Equal priorities go behind the ones already held.
            pos = 0;
            while (pos < held_key.size() &&
                   $signed(held_rank[pos]) <= $signed(beat.entry_rank))
              pos++;
            held_key.insert(pos, beat.entry_key);
            held_rank.insert(pos, beat.entry_rank);
          end
        end
        spq_pkg::CMD_POP: begin
          n_pop++;
          if (held_key.size() == 0) begin
            res.status = spq_pkg::ST_EMPTY;
            n_pop_empty++;
          end else begin
            res.popped_key = held_key.pop_front();
            void'(held_rank.pop_front());
          end
        end
        spq_pkg::CMD_CLEAR: begin
          n_clear++;
          held_key.delete();
          held_rank.delete();
        end
        default: n_ignored++;
      endcase
      if (held_key.size() > 0) begin
        res.front_key = held_key[0];
        res.front_rank = held_rank[0];
      end
      res.occupancy = spq_pkg::OCC_W'(held_key.size());
      res.is_empty = (held_key.size() == 0);
      if (held_key.size() > peak_fill)
        peak_fill = held_key.size();
      awaited_results.push_back(res);
    endfunction

    function void flag(string field, longint want, longint got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_beat(spq_pkg::out_t got);
      spq_pkg::out_t want;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected, got %h", $time, got);
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status)
        flag("status", want.status, got.status);
      if (got.popped_key !== want.popped_key)
        flag("popped_key", want.popped_key, got.popped_key);
      if (got.front_key !== want.front_key)
        flag("front_key", want.front_key, got.front_key);
      if (got.front_rank !== want.front_rank)
        flag("front_rank", $signed(want.front_rank), $signed(got.front_rank));
      if (got.occupancy !== want.occupancy)
        flag("occupancy", want.occupancy, got.occupancy);
      if (got.is_empty !== want.is_empty)
        flag("is_empty", want.is_empty, got.is_empty);
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction
  endclass

  // Every input of the block starts at a known value, with reset asserted.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  spq_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  spq_pkg::out_t out_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;

  urgency_scoreboard sb = new(CAPACITY);

  sorted_priority_queue_top #(.CAPACITY(CAPACITY)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // The receiver decides afresh each cycle whether to hold off the result channel.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Both monitors read the values that stood before the edge, so a beat is
  // seen exactly when the block takes it.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_command(in_data);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_beat(out_data);
  end

  // A hung block ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout with %0d results outstanding", $time, sb.outstanding());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic spq_pkg::in_t make_cmd(logic [1:0] cmd,
                                            logic [spq_pkg::KEY_W-1:0] key,
                                            logic signed [spq_pkg::RANK_W-1:0] rank);
    spq_pkg::in_t beat;
    beat.cmd = cmd;
    beat.entry_key = key;
    beat.entry_rank = rank;
    return beat;
  endfunction

  // Offers one beat and returns at the edge that takes it. The sender may
  // idle a few cycles first; once valid is up it stays up with the payload
  // held until the block stops stalling.
  task automatic send_beat(spq_pkg::in_t beat);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall);
  endtask

  // Random traffic in stretches, each with its own insert bias, so the queue
  // swings between empty and full rather than hovering at one level. A few
  // clears and unused codes are mixed in as noise.
  task automatic random_traffic(int beats);
    int sent;
    int stretch;
    int insert_pct;
    int roll;
    spq_pkg::in_t beat;
    sent = 0;
    while (sent < beats) begin
      stretch = $urandom_range(15, 40);
      case ($urandom_range(0, 3))
        0: insert_pct = 15;
        1: insert_pct = 50;
        2: insert_pct = 80;
        default: insert_pct = 95;
      endcase
      for (int i = 0; i < stretch && sent < beats; i++) begin
        beat.entry_key = spq_pkg::KEY_W'($urandom);
        // Narrow priority ranges make ties common; the others reach the extremes.
        case ($urandom_range(0, 3))
          0: beat.entry_rank = spq_pkg::RANK_W'($urandom);
          1: beat.entry_rank = spq_pkg::RANK_W'($urandom_range(0, 6) - 3);
          2: begin
            case ($urandom_range(0, 3))
              0: beat.entry_rank = 16'sh8000;
              1: beat.entry_rank = 16'sh7fff;
              2: beat.entry_rank = -16'sd1;
              default: beat.entry_rank = 16'sd0;
            endcase
          end
          default: beat.entry_rank = spq_pkg::RANK_W'($urandom_range(0, 600) - 300);
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 2)
          beat.cmd = spq_pkg::CMD_CLEAR;
        else if (roll < 4)
          beat.cmd = CMD_UNUSED;
        else if ($urandom_range(0, 99) < insert_pct)
          beat.cmd = spq_pkg::CMD_INSERT;
        else
          beat.cmd = spq_pkg::CMD_POP;
        send_beat(beat);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 27;
    recv_idle_pct = 52;

    // Directed part: empty-queue cases first, then the priority extremes,
    // a run of equal priorities that must leave in arrival order, then a
    // fill to capacity so that one more insert is dropped.
    send_beat(make_cmd(spq_pkg::CMD_POP, 16'h0000, 16'sd0));
    send_beat(make_cmd(CMD_UNUSED, 16'hffff, -16'sd1));
    send_beat(make_cmd(spq_pkg::CMD_INSERT, 16'h0000, 16'sh7fff));
    send_beat(make_cmd(spq_pkg::CMD_INSERT, 16'hffff, 16'sh8000));
    send_beat(make_cmd(spq_pkg::CMD_INSERT, 16'h1111, 16'sd5));
    send_beat(make_cmd(spq_pkg::CMD_INSERT, 16'h2222, 16'sd5));
    send_beat(make_cmd(spq_pkg::CMD_INSERT, 16'h3333, 16'sd5));
    send_beat(make_cmd(spq_pkg::CMD_POP, 16'h0000, 16'sd0));
    for (int i = 0; i < CAPACITY - 4; i++)
      send_beat(make_cmd(spq_pkg::CMD_INSERT, spq_pkg::KEY_W'(16'h4000 + i),
                         i[0] ? 16'sd5 : spq_pkg::RANK_W'(-i)));
    send_beat(make_cmd(spq_pkg::CMD_INSERT, 16'haaaa, 16'sh8000));
    send_beat(make_cmd(CMD_UNUSED, 16'h5555, 16'sd0));
    send_beat(make_cmd(spq_pkg::CMD_POP, 16'h0000, 16'sd0));
    send_beat(make_cmd(spq_pkg::CMD_CLEAR, 16'h0000, 16'sd0));
    send_beat(make_cmd(spq_pkg::CMD_POP, 16'h0000, 16'sd0));

    // Random part in three phases: slow receiver, then slow sender, then
    // back-to-back beats with no idling on either side.
    random_traffic(BEATS_PER_PHASE);
    send_idle_pct = 52;
    recv_idle_pct = 27;
    random_traffic(BEATS_PER_PHASE);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(BEATS_PER_PHASE);
    in_valid <= 1'b0;

    // Drain, then give a stray extra result beat time to show up.
    while (sb.outstanding() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d inserts (%0d dropped when full), %0d pops (%0d on empty),",
             sb.n_insert, sb.n_dropped, sb.n_pop, sb.n_pop_empty);
    $display("%0d clears and %0d unused codes; deepest queue held %0d entries.",
             sb.n_clear, sb.n_ignored, sb.peak_fill);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
